@@ hw/rtl/fwnf_pkg.sv @@
// fwnf_pkg: shared widths, register indexes, reset values and ascii codes
// for the fixed width number formatter; no dependencies
`default_nettype none

package fwnf_pkg;

    // port field widths
    localparam int VALUE_W    = 33;
    localparam int S_TDATA_W  = 40;
    localparam int CHAR_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    // register widths
    localparam int DEC_W  = 3;
    localparam int FW_W   = 6;
    localparam int FILL_W = 8;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DECIMALS     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FIELD_WIDTH  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FILL_CHAR    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_JUSTIFY_LEFT = 2'd3;

    // register reset values
    localparam logic [DEC_W-1:0]  RST_DECIMALS  = 3'd2;
    localparam logic [FW_W-1:0]   RST_WIDTH     = 6'd8;
    localparam logic [FILL_W-1:0] RST_FILL_CHAR = 8'h20;

    // ascii codes
    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] ASCII_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;

    // parameter defaults
    localparam int DEF_MAX_WIDTH    = 32;
    localparam int DEF_FRAC_BITS    = 16;
    localparam int DEF_MAX_DECIMALS = 4;

    // decimal digits needed for the largest value of an unsigned word
    function automatic int ndig_f(input int bits);
        longint unsigned v;
        int              n;
        v = (64'd1 << bits) - 64'd1;
        n = 0;
        while (v != 64'd0) begin
            v = v / 64'd10;
            n = n + 1;
        end
        return n;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/fixed_width_number_formatter_core.sv @@
// fixed_width_number_formatter_core: signed fixed point to padded decimal ascii,
// one character per output beat; depends on fwnf_pkg
`default_nettype none

//  channel   ports               content (lowest bit first)
//  config    cfg_wen/index/wdata register write, no read-back
//  input     s_t*                tdata: value[32:0], zero filled to 40 bits
//  output    m_t*                tdata: char_code; tlast: last; tuser: overflow
//
//  one number at a time: an accept step, bit-serial binary to bcd conversion over
//  the 32-FRAC_BITS integer bits, a step that drops leading zero digits, a setup
//  step, then one character per cycle while m_tready allows (field_width beats,
//  capped at MAX_WIDTH, when it fits)
//  m_tready low holds the beat and pauses the walk; the output register lets
//  the next number start while the last beat waits; aresetn is synchronous and
//  clears control state and the config registers

module fixed_width_number_formatter_core #(
    parameter int MAX_WIDTH    = fwnf_pkg::DEF_MAX_WIDTH,
    parameter int FRAC_BITS    = fwnf_pkg::DEF_FRAC_BITS,
    parameter int MAX_DECIMALS = fwnf_pkg::DEF_MAX_DECIMALS
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            cfg_wen,
    input  wire logic [fwnf_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [fwnf_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                            s_tvalid,
    output      logic                            s_tready,
    input  wire logic [fwnf_pkg::S_TDATA_W-1:0]  s_tdata,   // value[32:0]
    output      logic                            m_tvalid,
    input  wire logic                            m_tready,
    output      logic [fwnf_pkg::CHAR_W-1:0]     m_tdata,   // char_code[7:0]
    output      logic                            m_tlast,
    output      logic                            m_tuser    // overflow
);
    import fwnf_pkg::*;

    localparam int IBITS    = VALUE_W - 1 - FRAC_BITS;
    localparam int NDIG     = ndig_f(IBITS);
    localparam int BCD_W    = 4 * NDIG;
    localparam int TEXT_MAX = 2 + NDIG + MAX_DECIMALS;
    localparam int CW0      = $clog2(MAX_WIDTH + TEXT_MAX + 1);
    localparam int CW       = (CW0 > FW_W) ? CW0 : FW_W;
    localparam int BC_W     = $clog2(IBITS + 1);
    localparam int ND_W     = $clog2(NDIG + 1);

    typedef enum logic [9:0] {
        ST_IDLE  = 10'b0000000001,
        ST_CONV  = 10'b0000000010,
        ST_NORM  = 10'b0000000100,
        ST_FIELD = 10'b0000001000,
        ST_PADL  = 10'b0000010000,
        ST_SIGN  = 10'b0000100000,
        ST_INTD  = 10'b0001000000,
        ST_DOT   = 10'b0010000000,
        ST_FRAC  = 10'b0100000000,
        ST_PADR  = 10'b1000000000
    } state_t;

    state_t state_reg, state_next;

    logic [DEC_W-1:0]  dec_cfg_reg;
    logic [FW_W-1:0]   width_cfg_reg;
    logic [FILL_W-1:0] fill_reg;
    logic              just_reg;

    logic                 neg_reg, neg_next;
    logic [IBITS-1:0]     ishift_reg, ishift_next;
    logic [BCD_W-1:0]     bcd_reg, bcd_next;
    logic [FRAC_BITS-1:0] frac_reg, frac_next;
    logic [BC_W-1:0]      bit_cnt_reg, bit_cnt_next;
    logic [ND_W-1:0]      nd_reg, nd_next;
    logic [DEC_W-1:0]     dec_reg, dec_next;
    logic [DEC_W-1:0]     fc_reg, fc_next;
    logic [CW-1:0]        pad_reg, pad_next;
    logic [CW-1:0]        rem_reg, rem_next;
    logic                 ovf_reg, ovf_next;

    logic              out_valid_reg, out_valid_next;
    logic [CHAR_W-1:0] out_char_reg, out_char_next;
    logic              out_last_reg, out_last_next;
    logic              out_ovf_reg, out_ovf_next;

    // input stage
    logic [VALUE_W-1:0]   raw;
    logic [VALUE_W-1:0]   mag33;
    logic [VALUE_W-2:0]   mag;
    logic                 neg_in;
    // double dabble
    logic [BCD_W-1:0]     bcd_adj;
    logic [3:0]           top_dig;
    // fraction digit
    logic [FRAC_BITS+3:0] prod;
    // field setup
    logic [DEC_W-1:0]     dec_eff;
    logic [CW-1:0]        width_eff;
    logic [CW-1:0]        len_c;
    logic                 ovf_c;
    logic [CW-1:0]        pad_c;
    logic [CW-1:0]        rem_c;
    logic                 in_accept;
    logic                 out_free;
    logic                 is_emit;
    state_t               text_first;
    logic [CHAR_W-1:0]    ch_c;

    assign raw    = s_tdata[VALUE_W-1:0];
    assign neg_in = raw[VALUE_W-1];
    assign mag33  = neg_in ? (VALUE_W'(0) - raw) : raw;
    assign mag    = mag33[VALUE_W-1] ? '1 : mag33[VALUE_W-2:0];

    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            bcd_adj[4*i +: 4] = (bcd_reg[4*i +: 4] >= 4'd5) ? bcd_reg[4*i +: 4] + 4'd3
                                                            : bcd_reg[4*i +: 4];
        end
    end

    assign top_dig = bcd_reg[BCD_W-1 -: 4];
    assign prod    = {3'b000, frac_reg, 1'b0} + {1'b0, frac_reg, 3'b000};

    assign dec_eff   = (dec_cfg_reg > DEC_W'(MAX_DECIMALS)) ? DEC_W'(MAX_DECIMALS) : dec_cfg_reg;
    assign width_eff = (CW'(width_cfg_reg) > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH)
                                                              : CW'(width_cfg_reg);
    assign len_c     = CW'(neg_reg) + CW'(nd_reg)
                     + ((dec_eff != '0) ? (CW'(dec_eff) + CW'(1)) : CW'(0));
    assign ovf_c     = len_c > width_eff;
    assign pad_c     = width_eff - len_c;
    assign rem_c     = ovf_c ? ((len_c > CW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : len_c) : width_eff;

    assign s_tready   = (state_reg == ST_IDLE);
    assign in_accept  = s_tvalid && s_tready;
    assign out_free   = !out_valid_reg || m_tready;
    assign is_emit    = state_reg inside {ST_PADL, ST_SIGN, ST_INTD, ST_DOT, ST_FRAC, ST_PADR};
    assign text_first = neg_reg ? ST_SIGN : ST_INTD;

    always_comb begin
        case (state_reg)
            ST_PADL, ST_PADR: ch_c = fill_reg;
            ST_SIGN:          ch_c = ASCII_MINUS;
            ST_INTD:          ch_c = ASCII_ZERO + {4'h0, top_dig};
            ST_DOT:           ch_c = ASCII_DOT;
            ST_FRAC:          ch_c = ASCII_ZERO + {4'h0, prod[FRAC_BITS+3:FRAC_BITS]};
            default:          ch_c = fill_reg;
        endcase
    end

    always_comb begin
        state_next     = state_reg;
        neg_next       = neg_reg;
        ishift_next    = ishift_reg;
        bcd_next       = bcd_reg;
        frac_next      = frac_reg;
        bit_cnt_next   = bit_cnt_reg;
        nd_next        = nd_reg;
        dec_next       = dec_reg;
        fc_next        = fc_reg;
        pad_next       = pad_reg;
        rem_next       = rem_reg;
        ovf_next       = ovf_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_char_next  = out_char_reg;
        out_last_next  = out_last_reg;
        out_ovf_next   = out_ovf_reg;

        case (state_reg)
            ST_IDLE: begin
                if (in_accept) begin
                    neg_next     = neg_in;
                    ishift_next  = mag[VALUE_W-2:FRAC_BITS];
                    frac_next    = mag[FRAC_BITS-1:0];
                    bcd_next     = '0;
                    bit_cnt_next = BC_W'(IBITS);
                    state_next   = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next     = {bcd_adj[BCD_W-2:0], ishift_reg[IBITS-1]};
                ishift_next  = ishift_reg << 1;
                bit_cnt_next = bit_cnt_reg - BC_W'(1);
                if (bit_cnt_reg == BC_W'(1)) begin
                    nd_next    = ND_W'(NDIG);
                    state_next = ST_NORM;
                end
            end
            ST_NORM: begin
                // drop leading zero digits, keep at least one
                if (nd_reg > ND_W'(1) && top_dig == 4'd0) begin
                    bcd_next = bcd_reg << 4;
                    nd_next  = nd_reg - ND_W'(1);
                end else begin
                    state_next = ST_FIELD;
                end
            end
            ST_FIELD: begin
                dec_next = dec_eff;
                ovf_next = ovf_c;
                pad_next = pad_c;
                rem_next = rem_c;
                if (!ovf_c && !just_reg && pad_c != '0) begin
                    state_next = ST_PADL;
                end else begin
                    state_next = text_first;
                end
            end
            default: begin
                if (is_emit && out_free) begin
                    out_valid_next = 1'b1;
                    out_char_next  = ch_c;
                    out_last_next  = (rem_reg == CW'(1));
                    out_ovf_next   = ovf_reg;
                    rem_next       = rem_reg - CW'(1);
                    case (state_reg)
                        ST_PADL: begin
                            pad_next = pad_reg - CW'(1);
                            if (pad_reg == CW'(1)) begin
                                state_next = text_first;
                            end
                        end
                        ST_SIGN: begin
                            state_next = ST_INTD;
                        end
                        ST_INTD: begin
                            bcd_next = bcd_reg << 4;
                            nd_next  = nd_reg - ND_W'(1);
                            if (nd_reg == ND_W'(1)) begin
                                state_next = (dec_reg != '0) ? ST_DOT : ST_PADR;
                            end
                        end
                        ST_DOT: begin
                            fc_next    = dec_reg;
                            state_next = ST_FRAC;
                        end
                        ST_FRAC: begin
                            frac_next = prod[FRAC_BITS-1:0];
                            fc_next   = fc_reg - DEC_W'(1);
                            if (fc_reg == DEC_W'(1)) begin
                                state_next = ST_PADR;
                            end
                        end
                        default: begin
                            state_next = ST_PADR;
                        end
                    endcase
                    if (rem_reg == CW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end else if (!is_emit) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            dec_cfg_reg   <= RST_DECIMALS;
            width_cfg_reg <= RST_WIDTH;
            fill_reg      <= RST_FILL_CHAR;
            just_reg      <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wen) begin
                case (cfg_index)
                    REG_DECIMALS:     dec_cfg_reg   <= cfg_wdata[DEC_W-1:0];
                    REG_FIELD_WIDTH:  width_cfg_reg <= cfg_wdata[FW_W-1:0];
                    REG_FILL_CHAR:    fill_reg      <= cfg_wdata[FILL_W-1:0];
                    REG_JUSTIFY_LEFT: just_reg      <= cfg_wdata[0];
                    default:          just_reg      <= just_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        neg_reg      <= neg_next;
        ishift_reg   <= ishift_next;
        bcd_reg      <= bcd_next;
        frac_reg     <= frac_next;
        bit_cnt_reg  <= bit_cnt_next;
        nd_reg       <= nd_next;
        dec_reg      <= dec_next;
        fc_reg       <= fc_next;
        pad_reg      <= pad_next;
        rem_reg      <= rem_next;
        ovf_reg      <= ovf_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
        out_ovf_reg  <= out_ovf_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_char_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_ovf_reg;

endmodule

`default_nettype wire

@@ hw/rtl/fwnf_checker.sv @@
// fwnf_checker: port-level checks for fixed_width_number_formatter_core,
// bound into that core module; depends on fwnf_pkg
`default_nettype none

module fwnf_checker (
    input wire logic                        aclk,
    input wire logic                        aresetn,
    input wire logic                        s_tvalid,
    input wire logic                        s_tready,
    input wire logic                        m_tvalid,
    input wire logic                        m_tready,
    input wire logic [fwnf_pkg::CHAR_W-1:0] m_tdata,
    input wire logic                        m_tlast,
    input wire logic                        m_tuser
);
    import fwnf_pkg::*;

    // stalled output beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
                                  && $stable(m_tlast) && $stable(m_tuser))
        else $error("output beat changed while stalled");

    // one number in work at a time
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while a number is in work");

    // reset leaves no beat pending
    a_reset_clears: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind fixed_width_number_formatter_core fwnf_checker u_fwnf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire
